FILE: hw/rtl/report_frame_checker_defines.svh
// Assertion macros for the report frame checker's port-level assertions.
// Depends on nothing; included by rfc_checker.sv.
`ifndef REPORT_FRAME_CHECKER_DEFINES_SVH
`define REPORT_FRAME_CHECKER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define RFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal that must keep its value in the cycle after the condition holds.
`define RFC_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

FILE: hw/rtl/rfc_pkg.sv
// Types and constants for the report frame checker.
// Depends on nothing; used by the interfaces and all modules.
package rfc_pkg;

    localparam int REPORT_BYTES_DEF = 64;

    localparam logic [7:0] COMPLEMENT_MASK = 8'hFF;

    // Reset values of the configuration registers.
    localparam logic [7:0] HEADER_RESET = 8'd170;
    localparam logic [7:0] FOOTER_RESET = 8'd85;
    localparam logic [5:0] SIZE_LIMIT_RESET = 6'd48;
    localparam logic [7:0] LOCAL_ADDR_RESET = 8'd0;

    // Configuration register indexes.
    localparam logic [7:0] CFG_HEADER = 8'd0;
    localparam logic [7:0] CFG_FOOTER = 8'd1;
    localparam logic [7:0] CFG_SIZE_LIMIT = 8'd2;
    localparam logic [7:0] CFG_LOCAL_ADDR = 8'd3;

    // Status codes.
    localparam logic [2:0] ERR_OK = 3'd0;
    localparam logic [2:0] ERR_SIZE = 3'd1;
    localparam logic [2:0] ERR_KIND = 3'd2;
    localparam logic [2:0] ERR_DEST = 3'd3;
    localparam logic [2:0] ERR_FOOTER = 3'd4;
    localparam logic [2:0] ERR_CUT = 3'd5;

    // Result item kinds.
    localparam logic ITEM_PAYLOAD = 1'b0;
    localparam logic ITEM_STATUS = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DEST,
        PH_KIND,
        PH_SIZE,
        PH_DATA,
        PH_NKIND,
        PH_NDEST,
        PH_FOOT
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       report_start;
    } t_in_item;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        logic [5:0] payload_index;
        logic [7:0] frame_dest;
        logic [7:0] frame_kind;
        logic [7:0] frame_length;
        logic [2:0] error_code;
        logic       for_local;
    } t_out_item;

    typedef struct packed {
        logic [7:0] header_value;
        logic [7:0] footer_value;
        logic [5:0] size_limit;
        logic [7:0] local_address;
    } t_cfg;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_parse_res;

endpackage

FILE: hw/rtl/rfc_if.sv
// Valid/ready channel interfaces for the report frame checker.
// Depends on rfc_pkg for the payload types.
interface rfc_in_if;
    logic              valid;
    logic              ready;
    rfc_pkg::t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface rfc_out_if;
    logic               valid;
    logic               ready;
    rfc_pkg::t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface rfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] addr;
    logic [7:0] data;
    modport source(output valid, output addr, output data, input ready);
    modport sink(input valid, input addr, input data, output ready);
endinterface

FILE: hw/rtl/rfc_parser.sv
// Frame parser: phase register, held header fields and the per-byte result.
// Depends on rfc_pkg.
module rfc_parser #(
    parameter int REPORT_BYTES = rfc_pkg::REPORT_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  rfc_pkg::t_in_item   i_item,
    input  rfc_pkg::t_cfg       i_cfg,
    output rfc_pkg::t_parse_res o_res
);

    // A frame has seven bytes besides the payload and must fit in one report.
    localparam int CAP_RAW = REPORT_BYTES - 7;
    localparam logic [5:0] SIZE_CAP = (CAP_RAW > 63) ? 6'd63 : 6'(CAP_RAW);

    rfc_pkg::t_phase r_phase, n_phase;
    logic [5:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_held_dest, n_held_dest;
    logic [7:0] r_held_kind, n_held_kind;
    logic [7:0] r_held_length, n_held_length;

    logic [7:0] rx;
    logic [7:0] rx_inv;
    logic [5:0] eff_limit;
    logic       size_bad;

    assign rx = i_item.rx_byte;
    assign rx_inv = rx ^ rfc_pkg::COMPLEMENT_MASK;
    assign eff_limit = (i_cfg.size_limit < SIZE_CAP) ? i_cfg.size_limit : SIZE_CAP;
    assign size_bad = rx > {2'b00, eff_limit};

    always_comb begin
        n_phase = r_phase;
        n_bytes_left = r_bytes_left;
        n_held_dest = r_held_dest;
        n_held_kind = r_held_kind;
        n_held_length = r_held_length;
        if (i_item.report_start) begin
            n_bytes_left = '0;
            n_phase = rfc_pkg::PH_IDLE;
            if (rx == i_cfg.header_value) begin
                n_phase = rfc_pkg::PH_DEST;
                n_held_dest = '0;
                n_held_kind = '0;
                n_held_length = '0;
            end
        end else begin
            case (r_phase)
                rfc_pkg::PH_DEST: begin
                    n_held_dest = rx;
                    n_phase = rfc_pkg::PH_KIND;
                end
                rfc_pkg::PH_KIND: begin
                    n_held_kind = rx;
                    n_phase = rfc_pkg::PH_SIZE;
                end
                rfc_pkg::PH_SIZE: begin
                    n_held_length = rx;
                    if (size_bad) begin
                        n_phase = rfc_pkg::PH_IDLE;
                        n_bytes_left = '0;
                    end else begin
                        n_bytes_left = rx[5:0];
                        n_phase = (rx[5:0] != '0) ? rfc_pkg::PH_DATA : rfc_pkg::PH_NKIND;
                    end
                end
                rfc_pkg::PH_DATA: begin
                    n_bytes_left = r_bytes_left - 6'd1;
                    if (r_bytes_left == 6'd1) begin
                        n_phase = rfc_pkg::PH_NKIND;
                    end
                end
                rfc_pkg::PH_NKIND: begin
                    n_phase = (rx_inv != r_held_kind) ? rfc_pkg::PH_IDLE : rfc_pkg::PH_NDEST;
                end
                rfc_pkg::PH_NDEST: begin
                    n_phase = (rx_inv != r_held_dest) ? rfc_pkg::PH_IDLE : rfc_pkg::PH_FOOT;
                end
                rfc_pkg::PH_FOOT: begin
                    n_phase = rfc_pkg::PH_IDLE;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_comb begin
        o_res.valid = 1'b0;
        o_res.item.item_kind = rfc_pkg::ITEM_STATUS;
        o_res.item.payload_byte = '0;
        o_res.item.payload_index = '0;
        o_res.item.frame_dest = r_held_dest;
        o_res.item.frame_kind = r_held_kind;
        o_res.item.frame_length = r_held_length;
        o_res.item.error_code = rfc_pkg::ERR_OK;
        o_res.item.for_local = (r_held_dest == i_cfg.local_address);
        if (i_item.report_start) begin
            // A new report cuts short any frame still open.
            o_res.valid = i_accept && (r_phase != rfc_pkg::PH_IDLE);
            o_res.item.error_code = rfc_pkg::ERR_CUT;
        end else begin
            case (r_phase)
                rfc_pkg::PH_SIZE: begin
                    o_res.valid = i_accept && size_bad;
                    o_res.item.frame_length = rx;
                    o_res.item.error_code = rfc_pkg::ERR_SIZE;
                end
                rfc_pkg::PH_DATA: begin
                    o_res.valid = i_accept;
                    o_res.item.item_kind = rfc_pkg::ITEM_PAYLOAD;
                    o_res.item.payload_byte = rx;
                    o_res.item.payload_index = r_held_length[5:0] - r_bytes_left;
                end
                rfc_pkg::PH_NKIND: begin
                    o_res.valid = i_accept && (rx_inv != r_held_kind);
                    o_res.item.error_code = rfc_pkg::ERR_KIND;
                end
                rfc_pkg::PH_NDEST: begin
                    o_res.valid = i_accept && (rx_inv != r_held_dest);
                    o_res.item.error_code = rfc_pkg::ERR_DEST;
                end
                rfc_pkg::PH_FOOT: begin
                    o_res.valid = i_accept;
                    o_res.item.error_code = (rx == i_cfg.footer_value) ?
                        rfc_pkg::ERR_OK : rfc_pkg::ERR_FOOTER;
                end
                default: begin
                    o_res.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rfc_pkg::PH_IDLE;
            r_bytes_left <= '0;
            r_held_dest <= '0;
            r_held_kind <= '0;
            r_held_length <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_held_dest <= n_held_dest;
            r_held_kind <= n_held_kind;
            r_held_length <= n_held_length;
        end
    end

endmodule

FILE: hw/rtl/report_frame_checker.sv
// Report frame checker top level: configuration registers, parser and output buffer.
// Depends on rfc_pkg, rfc_if.sv and rfc_parser.
//
// The checker takes one received byte per clock cycle while its input is ready,
// and registers each result on acceptance: a tagged payload byte for every
// payload position, and one status request when a frame ends at its footer, on
// the first check that fails, or when a new report starts while a frame is open.
// The parse is a single phase register with short logic to a result register, backed
// by a second skid register, so input ready drops only when both hold undelivered
// results. Configuration writes are always ready and take effect at once.
module report_frame_checker #(
    parameter int REPORT_BYTES = rfc_pkg::REPORT_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rfc_cfg_if.sink   i_cfg,
    rfc_in_if.sink    i_in,
    rfc_out_if.source o_out
);

    rfc_pkg::t_cfg       r_cfg;
    rfc_pkg::t_parse_res parse_res;

    logic               in_accept;
    logic               out_take;
    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    rfc_pkg::t_out_item r_out, n_out;
    rfc_pkg::t_out_item r_skid, n_skid;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready = !r_skid_valid;
    assign in_accept = i_in.valid && !r_skid_valid;
    assign out_take = r_out_valid && o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_value <= rfc_pkg::HEADER_RESET;
            r_cfg.footer_value <= rfc_pkg::FOOTER_RESET;
            r_cfg.size_limit <= rfc_pkg::SIZE_LIMIT_RESET;
            r_cfg.local_address <= rfc_pkg::LOCAL_ADDR_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                rfc_pkg::CFG_HEADER:     r_cfg.header_value <= i_cfg.data;
                rfc_pkg::CFG_FOOTER:     r_cfg.footer_value <= i_cfg.data;
                rfc_pkg::CFG_SIZE_LIMIT: r_cfg.size_limit <= i_cfg.data[5:0];
                rfc_pkg::CFG_LOCAL_ADDR: r_cfg.local_address <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    rfc_parser #(
        .REPORT_BYTES(REPORT_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(in_accept),
        .i_item  (i_in.data),
        .i_cfg   (r_cfg),
        .o_res   (parse_res)
    );

    // A new result lands in the output register when it is free or draining,
    // otherwise in the skid register; no new result can arrive while the skid is full.
    always_comb begin
        n_out_valid = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out = r_out;
        n_skid = r_skid;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (parse_res.valid) begin
            if (!r_out_valid || out_take) begin
                n_out = parse_res.item;
                n_out_valid = 1'b1;
            end else begin
                n_skid = parse_res.item;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skid <= n_skid;
    end

endmodule

FILE: hw/rtl/rfc_checker.sv
// Port-level assertions for the report frame checker, bound to the top level.
// Depends on rfc_pkg and report_frame_checker_defines.svh.
`include "report_frame_checker_defines.svh"

module rfc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input rfc_pkg::t_out_item i_out_item
);

    logic out_stall;
    logic is_payload;

    assign out_stall = i_out_valid && !i_out_ready;
    assign is_payload = i_out_item.item_kind == rfc_pkg::ITEM_PAYLOAD;

    `RFC_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, out_stall, i_out_item, "stalled result changed")

    `RFC_ASSERT(a_full_has_out, i_clk, i_rst_n, !i_in_ready |-> i_out_valid, "input blocked with empty output")

    `RFC_ASSERT(a_stall_keeps_full, i_clk, i_rst_n, (out_stall && !i_in_ready) |=> !i_in_ready, "skid drained while output stalled")

    `RFC_ASSERT(a_code_range, i_clk, i_rst_n, i_out_valid |-> (i_out_item.error_code <= rfc_pkg::ERR_CUT), "undefined status code")

    `RFC_ASSERT(a_payload_clean, i_clk, i_rst_n, (i_out_valid && is_payload) |-> (i_out_item.error_code == rfc_pkg::ERR_OK), "payload item carries an error code")

endmodule

bind report_frame_checker rfc_checker u_rfc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_item (o_out.data)
);

FILE: test/rfc_deframe_checker.sv
// Watches the configuration, byte and result channels of the report frame checker,
// predicts every result from the accepted bytes, and compares field by field.
// Depends on rfc_pkg and the channel interfaces in rfc_if.sv.
module rfc_deframe_checker #(
    parameter int REPORT_BYTES = rfc_pkg::REPORT_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rfc_cfg_if   i_cfg,
    rfc_in_if    i_in,
    rfc_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rfc_pkg::*;

    t_cfg       regs;
    t_phase     frame_phase;
    logic [5:0] bytes_remaining;
    logic [7:0] seen_dest;
    logic [7:0] seen_kind;
    logic [7:0] seen_length;
    t_out_item  frame_outputs_due[$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    // A frame must fit in one report, and the size counter is six bits wide.
    function automatic logic [7:0] accepted_size_limit();
        int cap;
        cap = (REPORT_BYTES >= 7) ? REPORT_BYTES - 7 : 0;
        if (cap > 63) cap = 63;
        return (int'(regs.size_limit) < cap) ? {2'b00, regs.size_limit} : cap[7:0];
    endfunction

    function automatic t_out_item tag_item(input logic kind, input logic [7:0] b,
                                           input logic [5:0] idx, input logic [2:0] err);
        t_out_item r;
        r.item_kind = kind;
        r.payload_byte = b;
        r.payload_index = idx;
        r.frame_dest = seen_dest;
        r.frame_kind = seen_kind;
        r.frame_length = seen_length;
        r.error_code = err;
        r.for_local = (seen_dest == regs.local_address);
        return r;
    endfunction

    task automatic close_frame(input logic [2:0] code);
        frame_outputs_due.push_back(tag_item(ITEM_STATUS, 8'h00, 6'd0, code));
        frame_phase = PH_IDLE;
        bytes_remaining = '0;
    endtask

    task automatic deframe_byte(input t_in_item item);
        logic [7:0] b;
        b = item.rx_byte;
        if (item.report_start) begin
            // A new report closes any open frame, and its first byte may open the next one.
            if (frame_phase != PH_IDLE) close_frame(ERR_CUT);
            frame_phase = PH_IDLE;
            bytes_remaining = '0;
            if (b == regs.header_value) begin
                seen_dest = '0;
                seen_kind = '0;
                seen_length = '0;
                frame_phase = PH_DEST;
            end
            return;
        end
        case (frame_phase)
            PH_DEST: begin
                seen_dest = b;
                frame_phase = PH_KIND;
            end
            PH_KIND: begin
                seen_kind = b;
                frame_phase = PH_SIZE;
            end
            PH_SIZE: begin
                seen_length = b;
                if (b > accepted_size_limit()) begin
                    close_frame(ERR_SIZE);
                end else begin
                    bytes_remaining = b[5:0];
                    if (b == 8'd0) frame_phase = PH_NKIND;
                    else frame_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                frame_outputs_due.push_back(tag_item(ITEM_PAYLOAD, b,
                    seen_length[5:0] - bytes_remaining, ERR_OK));
                bytes_remaining = bytes_remaining - 6'd1;
                if (bytes_remaining == 6'd0) frame_phase = PH_NKIND;
            end
            PH_NKIND: begin
                if ((b ^ COMPLEMENT_MASK) != seen_kind) close_frame(ERR_KIND);
                else frame_phase = PH_NDEST;
            end
            PH_NDEST: begin
                if ((b ^ COMPLEMENT_MASK) != seen_dest) close_frame(ERR_DEST);
                else frame_phase = PH_FOOT;
            end
            PH_FOOT: begin
                close_frame((b == regs.footer_value) ? ERR_OK : ERR_FOOTER);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        o_fail_count++;
        $display("%0t ns: mismatch in %s: got %0d, wanted %0d", $time, what, got, want);
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (frame_outputs_due.size() == 0) begin
            report_mismatch("result with nothing due, item_kind", int'(got.item_kind), -1);
            return;
        end
        want = frame_outputs_due.pop_front();
        if (got.item_kind != want.item_kind)
            report_mismatch("item_kind", int'(got.item_kind), int'(want.item_kind));
        if (got.payload_byte != want.payload_byte)
            report_mismatch("payload_byte", int'(got.payload_byte), int'(want.payload_byte));
        if (got.payload_index != want.payload_index)
            report_mismatch("payload_index", int'(got.payload_index),
                            int'(want.payload_index));
        if (got.frame_dest != want.frame_dest)
            report_mismatch("frame_dest", int'(got.frame_dest), int'(want.frame_dest));
        if (got.frame_kind != want.frame_kind)
            report_mismatch("frame_kind", int'(got.frame_kind), int'(want.frame_kind));
        if (got.frame_length != want.frame_length)
            report_mismatch("frame_length", int'(got.frame_length), int'(want.frame_length));
        if (got.error_code != want.error_code)
            report_mismatch("error_code", int'(got.error_code), int'(want.error_code));
        if (got.for_local != want.for_local)
            report_mismatch("for_local", int'(got.for_local), int'(want.for_local));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.header_value = HEADER_RESET;
            regs.footer_value = FOOTER_RESET;
            regs.size_limit = SIZE_LIMIT_RESET;
            regs.local_address = LOCAL_ADDR_RESET;
            frame_phase = PH_IDLE;
            bytes_remaining = '0;
            seen_dest = '0;
            seen_kind = '0;
            seen_length = '0;
            frame_outputs_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.addr)
                    CFG_HEADER:     regs.header_value = i_cfg.data;
                    CFG_FOOTER:     regs.footer_value = i_cfg.data;
                    CFG_SIZE_LIMIT: regs.size_limit = i_cfg.data[5:0];
                    CFG_LOCAL_ADDR: regs.local_address = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) deframe_byte(i_in.data);
            if (i_out.valid && i_out.ready) check_result(i_out.data);
        end
        o_pending = frame_outputs_due.size();
    end

endmodule

FILE: test/tb_report_frame_checker.sv
// Top of the report frame checker testbench: clock, reset, configuration and byte
// stimulus, result-side stalls, and the verdict. Depends on rfc_pkg, rfc_if.sv,
// the block itself and rfc_deframe_checker.
module tb_report_frame_checker;
    timeunit 1ns;
    timeprecision 1ps;
    import rfc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_BYTES = 750;
    localparam int PHASES = 6;
    localparam int SIZE_CAP = REPORT_BYTES_DEF - 7;

    typedef enum int {
        FAULT_NONE,
        FAULT_OVERSIZE,
        FAULT_KIND,
        FAULT_DEST,
        FAULT_FOOTER,
        FAULT_CUT,
        FAULT_HEADER
    } t_fault;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    bit   gaps_on = 1'b0;
    bit   stalls_on = 1'b0;
    t_cfg cur_cfg;

    rfc_in_if  in_ch();
    rfc_out_if out_ch();
    rfc_cfg_if cfg_ch();

    report_frame_checker dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    rfc_deframe_checker mon (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_ch),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The result side stalls in random bursts while stalls are enabled.
    initial begin
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) hold--;
            else if (stalls_on && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 16);
            out_ch.ready <= (hold == 0);
        end
    end

    // Entered and left at a falling edge; valid stays high for a following request.
    task automatic send_byte(input logic [7:0] b, input logic start);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= '{rx_byte: b, report_start: start};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr <= idx;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_config(input t_cfg c);
        write_reg(CFG_HEADER, c.header_value);
        write_reg(CFG_FOOTER, c.footer_value);
        write_reg(CFG_SIZE_LIMIT, {2'b00, c.size_limit});
        write_reg(CFG_LOCAL_ADDR, c.local_address);
        cfg_ch.valid <= 1'b0;
        cur_cfg = c;
    endtask

    // Bytes that cause no result may still be in the parser when the last result
    // is out, so the task waits on past that point before the block counts as idle.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] dest, input logic [7:0] kind,
                              input logic [7:0] size, input t_fault fault);
        logic [7:0] body[$];
        logic [7:0] header;
        int         cut_at;
        body.push_back(dest);
        body.push_back(kind);
        body.push_back(size);
        // After an oversize length the block is idle, so nothing more is sent.
        if (fault != FAULT_OVERSIZE) begin
            repeat (size) body.push_back(8'($urandom_range(0, 255)));
            body.push_back(fault == FAULT_KIND ? ~kind ^ 8'($urandom_range(1, 255)) : ~kind);
            body.push_back(fault == FAULT_DEST ? ~dest ^ 8'($urandom_range(1, 255)) : ~dest);
            body.push_back(fault == FAULT_FOOTER ?
                           cur_cfg.footer_value ^ 8'($urandom_range(1, 255)) :
                           cur_cfg.footer_value);
        end
        header = cur_cfg.header_value;
        if (fault == FAULT_HEADER) header = header ^ 8'($urandom_range(1, 255));
        send_byte(header, 1'b1);
        cut_at = (fault == FAULT_CUT) ? $urandom_range(0, body.size() - 1) : body.size();
        for (int i = 0; i < cut_at; i++) send_byte(body[i], 1'b0);
    endtask

    function automatic int size_ceiling();
        return (int'(cur_cfg.size_limit) < SIZE_CAP) ? int'(cur_cfg.size_limit) : SIZE_CAP;
    endfunction

    function automatic logic [7:0] pick_size(input t_fault fault);
        int lim;
        int r;
        lim = size_ceiling();
        r = $urandom_range(0, 9);
        if (fault == FAULT_OVERSIZE) begin
            if (r < 3) return 8'(lim + 1);
            if (r == 3) return 8'd255;
            return 8'($urandom_range(lim + 1, 255));
        end
        if (r == 0) return 8'(lim);
        if (r == 1) return 8'd0;
        return 8'($urandom_range(0, (lim < 8) ? lim : 8));
    endfunction

    function automatic t_fault pick_fault();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return FAULT_NONE;
        if (r < 70) return FAULT_OVERSIZE;
        if (r < 76) return FAULT_KIND;
        if (r < 82) return FAULT_DEST;
        if (r < 88) return FAULT_FOOTER;
        if (r < 95) return FAULT_CUT;
        return FAULT_HEADER;
    endfunction

    task automatic send_random_frame(input t_fault fault);
        logic [7:0] dest;
        dest = ($urandom_range(0, 3) == 0) ? cur_cfg.local_address : 8'($urandom_range(0, 255));
        send_frame(dest, 8'($urandom_range(0, 255)), pick_size(fault), fault);
        // Padding of the report after the frame is ignored by the block unless the frame was cut short.
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic run_random(input int count);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < count) send_random_frame(pick_fault());
        // A clean frame last, so no frame is left open across a register change.
        send_random_frame(FAULT_NONE);
    endtask

    initial begin
        t_cfg plan[PHASES];
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = '0;
        cfg_ch.data = '0;
        cur_cfg = '{HEADER_RESET, FOOTER_RESET, SIZE_LIMIT_RESET, LOCAL_ADDR_RESET};

        plan[0] = '{8'h00, 8'hFF, 6'd63, 8'hFF};
        plan[1] = '{8'hFF, 8'h00, 6'd0, 8'h5A};
        for (int p = 2; p < PHASES - 1; p++)
            plan[p] = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        6'($urandom_range(0, 63)), 8'($urandom_range(0, 255))};
        plan[PHASES - 1] = '{HEADER_RESET, FOOTER_RESET, 6'd57, 8'h00};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames under the reset settings.
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        send_frame(8'h00, 8'hFF, 8'd1, FAULT_NONE);
        send_frame(8'hFF, 8'h00, 8'd0, FAULT_NONE);
        send_frame(8'h12, 8'h34, 8'd49, FAULT_OVERSIZE);
        send_frame(8'h01, 8'h02, 8'd0, FAULT_KIND);
        send_frame(8'h03, 8'h04, 8'd0, FAULT_DEST);
        send_frame(8'h05, 8'h06, 8'd0, FAULT_FOOTER);
        send_frame(8'h07, 8'h08, 8'd0, FAULT_CUT);
        send_frame(8'h09, 8'h0A, 8'd0, FAULT_HEADER);
        send_byte(8'hAA, 1'b0);
        send_frame(8'h0B, 8'h0C, 8'd2, FAULT_NONE);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p == PHASES - 1) begin
                gaps_on = 1'b0;
                stalls_on = 1'b0;
            end
            apply_config(plan[p]);
            // The widest limit: largest payload index, and one byte past the cap.
            if (p == 0) begin
                send_frame(8'hFF, 8'h55, 8'(SIZE_CAP), FAULT_NONE);
                send_frame(8'h00, 8'h55, 8'(SIZE_CAP + 1), FAULT_OVERSIZE);
            end
            run_random(RANDOM_BYTES / PHASES);
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rfc_pkg.sv
hw/rtl/rfc_if.sv
hw/rtl/rfc_parser.sv
hw/rtl/report_frame_checker.sv
hw/rtl/rfc_checker.sv
test/rfc_deframe_checker.sv
test/tb_report_frame_checker.sv
